FILE: hw/rtl/timestamped_slot_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Timestamped slot queue: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_SLOT_QUEUE_CORE_DEFINES_SVH
`define TIMESTAMPED_SLOT_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define TSQ_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped slot queue: package
// Sizes, operation codes and the structs passed between the blocks.
// ----------------------------------------------------------------------------
package tsq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int N_W     = $clog2(DEPTH + 1);
  localparam int GUARD_W = $clog2(DEPTH + 2);
  localparam int STAMP_W = 64;
  localparam int LEN_W   = 16;
  localparam int MODE_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int STALE_W = 32;
  localparam int THR_W   = 43;
  localparam int ENTRY_W = STAMP_W + LEN_W;

  localparam int CNT_MAX   = 31;
  localparam int NS_PER_US = 1000;

  localparam logic [STALE_W-1:0] MAX_STALE_RST = 32'd1000000;
  // (max_stale_us + 1) * 1000 at reset
  localparam logic [THR_W-1:0] THR_RST = THR_W'((64'(MAX_STALE_RST) + 64'd1) * 64'd1000);

  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PULL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TAKE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GIVE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               ignore_time;
    logic [STAMP_W-1:0] now_ns;
    logic [STAMP_W-1:0] stamp_ns;
    logic [LEN_W-1:0]   length;
    logic [SLOT_W-1:0]  slot;
  } tsq_req_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  out_slot;
    logic [LEN_W-1:0]   out_length;
    logic [STAMP_W-1:0] out_stamp_ns;
    logic [CNT_W-1:0]   ready_count;
  } tsq_res_t;

  typedef struct packed {
    logic             purge_off;
    logic [THR_W-1:0] stale_thr_ns;
  } tsq_cfg_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (32'(i) == DEPTH - 1) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/tsq_slot_ram.sv
// ----------------------------------------------------------------------------
// Timestamped slot queue: slot RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsq_slot_ram #(
  parameter int WIDTH = 80,
  parameter int WORDS = 16,
  parameter int AW    = $clog2(WORDS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/tsq_ctrl.sv
// ----------------------------------------------------------------------------
// Timestamped slot queue: sequencer
// Runs one request at a time: pointer advance, purge, count walk, give scan.
// ----------------------------------------------------------------------------
module tsq_ctrl
  import tsq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start_i,
  input  tsq_req_t req_i,
  input  tsq_cfg_t cfg_i,
  output logic     idle_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output tsq_res_t res_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_ADV        = 4'd2;
  localparam logic [3:0] S_PURGE_RD   = 4'd3;
  localparam logic [3:0] S_PURGE_DIFF = 4'd4;
  localparam logic [3:0] S_PURGE_EVAL = 4'd5;
  localparam logic [3:0] S_PEEK_RD    = 4'd6;
  localparam logic [3:0] S_PEEK_EVAL  = 4'd7;
  localparam logic [3:0] S_CNT_INIT   = 4'd8;
  localparam logic [3:0] S_CNT_RD     = 4'd9;
  localparam logic [3:0] S_CNT_EVAL   = 4'd10;
  localparam logic [3:0] S_TAKE_EVAL  = 4'd11;
  localparam logic [3:0] S_GIVE_SCAN  = 4'd12;
  localparam logic [3:0] S_DONE       = 4'd13;

  logic [3:0]         state_r, state_nxt;
  logic [3:0]         ret_r, ret_nxt;
  tsq_req_t           req_r, req_nxt;
  tsq_res_t           res_r, res_nxt;
  logic [DEPTH-1:0]   taken_r, taken_nxt;
  logic [DEPTH-1:0]   lenv_r, lenv_nxt;      // length valid, clear reads as zero
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               head_act_r, head_act_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic               tail_act_r, tail_act_nxt;
  logic               ff_r, ff_nxt;          // sticky first-future
  logic               adv_tail_r, adv_tail_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic               first_r, first_nxt;
  logic [GUARD_W-1:0] guard_r, guard_nxt;
  logic [STAMP_W-1:0] diff_r, diff_nxt;
  logic               ge_r, ge_nxt;
  logic               le_r, le_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   vis_r, vis_nxt;
  logic [N_W-1:0]     n_r, n_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [STAMP_W-1:0] rd_stamp;
  logic [LEN_W-1:0]   rd_len;

  assign rd_stamp = ram_rdata[ENTRY_W-1:LEN_W];
  assign rd_len   = ram_rdata[LEN_W-1:0];

  tsq_slot_ram #(
    .WIDTH (ENTRY_W),
    .WORDS (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idle_o      = (state_r == S_IDLE);
  assign res_valid_o = (state_r == S_DONE);
  assign res_o       = res_r;

  always_comb begin
    logic [IDX_W-1:0] a_ptr;
    logic [IDX_W-1:0] a_other;
    logic             a_oact;
    logic [IDX_W:0]   a_sum;
    logic [IDX_W-1:0] a_idx;
    logic             drop;
    logic             ff_new;
    logic             brk;
    logic [N_W-1:0]   n_new;
    logic [IDX_W-1:0] i_new;
    logic [3:0]       post;

    state_nxt    = state_r;
    ret_nxt      = ret_r;
    req_nxt      = req_r;
    res_nxt      = res_r;
    taken_nxt    = taken_r;
    lenv_nxt     = lenv_r;
    head_nxt     = head_r;
    head_act_nxt = head_act_r;
    tail_nxt     = tail_r;
    tail_act_nxt = tail_act_r;
    ff_nxt       = ff_r;
    adv_tail_nxt = adv_tail_r;
    k_nxt        = k_r;
    first_nxt    = first_r;
    guard_nxt    = guard_r;
    diff_nxt     = diff_r;
    ge_nxt       = ge_r;
    le_nxt       = le_r;
    idx_nxt      = idx_r;
    vis_nxt      = vis_r;
    n_nxt        = n_r;
    ram_we       = 1'b0;
    ram_waddr    = head_r;
    ram_wdata    = {req_r.stamp_ns, req_r.length};
    ram_raddr    = tail_r;
    drop         = 1'b0;
    ff_new       = ff_r;
    brk          = 1'b0;
    n_new        = n_r;
    i_new        = idx_r;

    post = (req_r.mode == MODE_PEEK) ? S_PEEK_RD : S_CNT_INIT;

    // one probe of the pointer advance
    a_ptr   = adv_tail_r ? tail_r : head_r;
    a_other = adv_tail_r ? head_r : tail_r;
    a_oact  = adv_tail_r ? head_act_r : tail_act_r;
    a_sum   = {1'b0, a_ptr} + {1'b0, k_r};
    if (32'(a_sum) >= DEPTH) begin
      a_sum = a_sum - (IDX_W+1)'(DEPTH);
    end
    a_idx = a_sum[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          req_nxt   = req_i;
          res_nxt   = '0;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        k_nxt = IDX_W'(1);
        case (req_r.mode)
          MODE_PUSH: begin
            state_nxt = S_DONE;
            if (head_act_r) begin
              ram_we         = 1'b1;
              lenv_nxt[head_r] = 1'b1;
              if (!tail_act_r) begin
                tail_nxt     = head_r;
                tail_act_nxt = 1'b1;
              end
              res_nxt.ok   = 1'b1;
              adv_tail_nxt = 1'b0;
              ret_nxt      = S_DONE;
              state_nxt    = S_ADV;
            end
          end
          MODE_PEEK, MODE_COUNT: begin
            if (req_r.mode == MODE_COUNT) begin
              res_nxt.ok = 1'b1;
            end
            if (req_r.ignore_time || cfg_i.purge_off) begin
              state_nxt = post;
            end else begin
              first_nxt = 1'b1;
              guard_nxt = '0;
              state_nxt = S_PURGE_RD;
            end
          end
          MODE_PULL: begin
            state_nxt = S_DONE;
            if (tail_act_r) begin
              if (!head_act_r) begin
                head_nxt     = tail_r;
                head_act_nxt = 1'b1;
              end
              lenv_nxt[tail_r] = 1'b0;
              res_nxt.ok   = 1'b1;
              adv_tail_nxt = 1'b1;
              ret_nxt      = S_DONE;
              state_nxt    = S_ADV;
            end
          end
          MODE_TAKE: begin
            state_nxt = S_DONE;
            if (tail_act_r) begin
              state_nxt = S_TAKE_EVAL;
            end
          end
          MODE_GIVE: begin
            state_nxt = S_DONE;
            if (32'(req_r.slot) < DEPTH) begin
              taken_nxt[IDX_W'(req_r.slot)] = 1'b0;
              lenv_nxt[IDX_W'(req_r.slot)]  = 1'b0;
              res_nxt.ok = 1'b1;
              if (!head_act_r) begin
                idx_nxt   = '0;
                state_nxt = S_GIVE_SCAN;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_ADV: begin
        if (a_oact && a_idx == a_other) begin
          if (adv_tail_r) tail_act_nxt = 1'b0;
          else            head_act_nxt = 1'b0;
          state_nxt = ret_r;
        end else if (!taken_r[a_idx]) begin
          if (adv_tail_r) tail_nxt = a_idx;
          else            head_nxt = a_idx;
          state_nxt = ret_r;
        end else if (32'(k_r) == DEPTH - 1) begin
          if (adv_tail_r) tail_act_nxt = 1'b0;
          else            head_act_nxt = 1'b0;
          state_nxt = ret_r;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end

      S_PURGE_RD: begin
        ram_raddr = tail_r;
        if (32'(guard_r) <= DEPTH && tail_act_r) begin
          state_nxt = S_PURGE_DIFF;
        end else begin
          state_nxt = post;
        end
      end

      S_PURGE_DIFF: begin
        ge_nxt    = (rd_stamp >= req_r.now_ns);
        le_nxt    = (rd_stamp <= req_r.now_ns);
        diff_nxt  = req_r.now_ns - rd_stamp;
        state_nxt = S_PURGE_EVAL;
      end

      S_PURGE_EVAL: begin
        if (first_r) begin
          // age in whole us: zero below 1000 ns, stale at or past the threshold
          if (ge_r || diff_r < STAMP_W'(NS_PER_US)) begin
            ff_new = 1'b1;
          end else if (diff_r >= STAMP_W'(cfg_i.stale_thr_ns)) begin
            drop   = 1'b1;
            ff_new = 1'b0;
          end
          first_nxt = 1'b0;
        end else begin
          if (le_r) drop   = 1'b1;
          else      ff_new = 1'b1;
        end
        ff_nxt = ff_new;
        if (drop || !ff_new) begin
          if (!head_act_r) begin
            head_nxt     = tail_r;
            head_act_nxt = 1'b1;
          end
          lenv_nxt[tail_r] = 1'b0;
          guard_nxt    = guard_r + GUARD_W'(1);
          adv_tail_nxt = 1'b1;
          k_nxt        = IDX_W'(1);
          ret_nxt      = S_PURGE_RD;
          state_nxt    = S_ADV;
        end else begin
          state_nxt = post;
        end
      end

      S_PEEK_RD: begin
        ram_raddr = tail_r;
        state_nxt = tail_act_r ? S_PEEK_EVAL : S_DONE;
      end

      S_PEEK_EVAL: begin
        if (req_r.ignore_time || rd_stamp <= req_r.now_ns) begin
          res_nxt.ok           = 1'b1;
          res_nxt.out_slot     = SLOT_W'(tail_r);
          res_nxt.out_length   = lenv_r[tail_r] ? rd_len : '0;
          res_nxt.out_stamp_ns = rd_stamp;
        end
        state_nxt = S_DONE;
      end

      S_TAKE_EVAL: begin
        res_nxt.ok           = 1'b1;
        res_nxt.out_slot     = SLOT_W'(tail_r);
        res_nxt.out_length   = lenv_r[tail_r] ? rd_len : '0;
        res_nxt.out_stamp_ns = rd_stamp;
        taken_nxt[tail_r]    = 1'b1;   // advance never revisits its start
        adv_tail_nxt         = 1'b1;
        k_nxt                = IDX_W'(1);
        ret_nxt              = S_DONE;
        state_nxt            = S_ADV;
      end

      S_CNT_INIT: begin
        idx_nxt   = tail_r;
        vis_nxt   = '0;
        n_nxt     = '0;
        state_nxt = tail_act_r ? S_CNT_RD : S_DONE;
      end

      S_CNT_RD: begin
        ram_raddr = idx_r;
        state_nxt = S_CNT_EVAL;
      end

      S_CNT_EVAL: begin
        if (!taken_r[idx_r]) begin
          if (!req_r.ignore_time && rd_stamp > req_r.now_ns) begin
            brk = 1'b1;
          end else begin
            n_new = n_r + N_W'(1);
          end
        end
        i_new = idx_inc(idx_r);
        if (!brk) begin
          if (head_act_r && i_new == head_r) brk = 1'b1;
          if (32'(n_new) >= DEPTH)          brk = 1'b1;
          if (32'(vis_r) == DEPTH - 1)      brk = 1'b1;
        end
        n_nxt   = n_new;
        idx_nxt = i_new;
        vis_nxt = vis_r + IDX_W'(1);
        if (brk) begin
          res_nxt.ready_count = (32'(n_new) > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(n_new);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CNT_RD;
        end
      end

      S_GIVE_SCAN: begin
        if (!taken_r[idx_r]) begin
          head_nxt     = idx_r;
          head_act_nxt = 1'b1;
          state_nxt    = S_DONE;
        end else if (32'(idx_r) == DEPTH - 1) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      taken_r    <= '0;
      lenv_r     <= '0;
      head_r     <= '0;
      head_act_r <= 1'b1;
      tail_r     <= '0;
      tail_act_r <= 1'b0;
      ff_r       <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      taken_r    <= taken_nxt;
      lenv_r     <= lenv_nxt;
      head_r     <= head_nxt;
      head_act_r <= head_act_nxt;
      tail_r     <= tail_nxt;
      tail_act_r <= tail_act_nxt;
      ff_r       <= ff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    adv_tail_r <= adv_tail_nxt;
    k_r        <= k_nxt;
    first_r    <= first_nxt;
    guard_r    <= guard_nxt;
    diff_r     <= diff_nxt;
    ge_r       <= ge_nxt;
    le_r       <= le_nxt;
    idx_r      <= idx_nxt;
    vis_r      <= vis_nxt;
    n_r        <= n_nxt;
  end

endmodule

FILE: hw/rtl/timestamped_slot_queue_core.sv
// ----------------------------------------------------------------------------
// Timestamped slot queue core
// Ring of 16 slots (stamp, length, taken) with push/peek/pull/take/give/count.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Content
// in_*      in   tvalid/tready      request: mode, flag in tuser; times, len, slot
// out_*     out  tvalid/tready      result: ok, slot, length, stamp, ready count
// cfg_*     in   cfg_wen            max_stale_us, taken on any edge with cfg_wen
//
// One request is worked at a time by the sequencer over the slot RAM (one
// read, one write a cycle, read data in the next cycle). Push, pull, take
// and give may end in a one-slot-per-cycle pointer scan. Peek and count add
// a purge of up to DEPTH+1 tail slots, each read, differenced and evaluated,
// plus a pointer scan, and count walks up to DEPTH slots, each read then
// evaluated. A new request is accepted while the previous result still waits
// in the output register. Reset is synchronous and needs no clearing pass.
//
`include "timestamped_slot_queue_core_defines.svh"

module timestamped_slot_queue_core
  import tsq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: now_ns[63:0], stamp_ns[127:64], length[143:128], slot[147:144]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,
  // in_tuser: mode[2:0], ignore_time[3]
  input  logic [3:0]   in_tuser,
  // out_tdata: ok[0], out_slot[4:1], out_length[20:5], out_stamp_ns[84:21],
  //            ready_count[89:85]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata
);

  tsq_req_t req;
  tsq_res_t res;
  tsq_cfg_t cfg;
  logic     start;
  logic     idle;
  logic     res_valid;
  logic     res_ready;
  logic     load;

  logic             purge_off_r, purge_off_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic             out_valid_r, out_valid_nxt;
  tsq_res_t         out_res_r, out_res_nxt;

  // Request unpacking
  assign req.mode        = in_tuser[2:0];
  assign req.ignore_time = in_tuser[3];
  assign req.now_ns      = in_tdata[63:0];
  assign req.stamp_ns    = in_tdata[127:64];
  assign req.length      = in_tdata[143:128];
  assign req.slot        = in_tdata[147:144];

  assign in_tready = idle;
  assign start     = in_tvalid && idle;

  // Stale threshold kept in ns: age/1000 > max  <=>  age >= (max+1)*1000
  always_comb begin
    purge_off_nxt = purge_off_r;
    thr_nxt       = thr_r;
    if (cfg_wen) begin
      purge_off_nxt = (cfg_wdata == '0);
      thr_nxt = (THR_W'(cfg_wdata) + THR_W'(1)) * THR_W'(NS_PER_US);
    end
  end

  assign cfg.purge_off    = purge_off_r;
  assign cfg.stale_thr_ns = thr_r;

  tsq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .req_i       (req),
    .cfg_i       (cfg),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register; refilled in the same cycle it drains
  assign res_ready = !out_valid_r || out_tready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      purge_off_r <= 1'b0;
      thr_r       <= THR_RST;
      out_valid_r <= 1'b0;
    end else begin
      purge_off_r <= purge_off_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.ready_count, out_res_r.out_stamp_ns,
                       out_res_r.out_length, out_res_r.out_slot, out_res_r.ok};

  // A request occupies the sequencer for at least the following cycle
  `TSQ_ASSERT_NEXT(a_busy_after_accept, start, !in_tready, "accepted request did not start")
  // A finished result always lands in the output register
  `TSQ_ASSERT_NEXT(a_result_loaded, load, out_tvalid, "result not presented")
  // A nonzero ready count only comes from count, which always succeeds
  `TSQ_ASSERT_HOLDS(a_count_ok, out_tvalid && out_res_r.ready_count != '0,
                    out_res_r.ok, "ready count without ok")

endmodule
